/* rtl/core/b2s_pkg.sv */
// Package for the batch-to-space address map: field widths, register indexes,
// pipeline stage types and the shared division step function.
// Depends on nothing; used by rtl/core/batch_to_space_address_map.sv.
package b2s_pkg;

   localparam int LANES       = 4;
   localparam int LANE_W      = 32;
   localparam int BATCH_W     = 16;
   localparam int CHB_W       = 10;
   localparam int POS_W       = 12;
   localparam int ADDR_W      = 42;
   localparam int REQ_DATA_W  = 184;
   localparam int RSP_DATA_W  = 176;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_BITS    = BATCH_W / DIV_STAGES;
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OUT_BATCH      = 3'd0,
      REG_BLOCK_HEIGHT   = 3'd1,
      REG_BLOCK_WIDTH    = 3'd2,
      REG_CROP_TOP       = 3'd3,
      REG_CROP_LEFT      = 3'd4,
      REG_OUT_HEIGHT     = 3'd5,
      REG_OUT_WIDTH      = 3'd6,
      REG_CHANNEL_BLOCKS = 3'd7
   } csr_index_type;

   typedef logic [LANES-1:0][LANE_W-1:0] lanes_type;

   // Division stages: batch / out_batch feeds its quotient bits, most
   // significant first, straight into the division by block width.
   typedef struct packed {
      logic [BATCH_W-1:0] ib;
      logic [8:0]         rem_b;
      logic [4:0]         rem_w;
      logic [BATCH_W-1:0] quo_w;
      logic [CHB_W-1:0]   cb;
      logic [16:0]        row_prod;
      logic [16:0]        col_prod;
      lanes_type          lanes;
   } div_type;

   typedef struct packed {
      logic [20:0] base;
      logic [18:0] row;
      logic [18:0] col;
      lanes_type   lanes;
   } pos_type;

   typedef struct packed {
      logic        drop;
      logic [33:0] part;
      logic [12:0] col;
      lanes_type   lanes;
   } mac_type;

   typedef struct packed {
      logic              drop;
      logic [ADDR_W-1:0] addr;
      lanes_type         lanes;
   } out_type;

   function automatic div_type div_slice(input div_type acc, input logic [8:0] nb,
                                         input logic [4:0] bw);
      div_type    res;
      logic [9:0] t1;
      logic [5:0] t2;
      logic       qb;
      logic       qw;
      res = acc;
      for (int i = 0; i < DIV_BITS; i++) begin
         t1     = {res.rem_b, res.ib[BATCH_W-1]};
         res.ib = {res.ib[BATCH_W-2:0], 1'b0};
         if (t1 >= {1'b0, nb}) begin
            t1 = t1 - {1'b0, nb};
            qb = 1'b1;
         end else begin
            qb = 1'b0;
         end
         res.rem_b = t1[8:0];
         t2 = {res.rem_w, qb};
         if (t2 >= {1'b0, bw}) begin
            t2 = t2 - {1'b0, bw};
            qw = 1'b1;
         end else begin
            qw = 1'b0;
         end
         res.rem_w = t2[4:0];
         res.quo_w = {res.quo_w[BATCH_W-2:0], qw};
      end
      return res;
   endfunction

endpackage

/* rtl/core/batch_to_space_address_map.sv */
// Top level of the batch-to-space address map: a seven-stage pipeline with
// register file, division stages, row and column math and address multiply.
// Depends on rtl/core/b2s_pkg.sv.
//
// Each word on the req_ channel is one four-lane channel block of the input
// tensor; each word on the rsp_ channel gives its output block address and the
// lanes, or a dropped flag on rsp_tuser with zero data when the element falls
// in the cropped area. Every request word yields exactly one response word,
// in order.
// The csr_ port sets the output shape, block shape and crops; write it only
// while no word is in flight.
// One word is taken every cycle unless the pipeline is full and stalled:
// four stages of a shared-width restoring divider (four quotient bits each)
// set the depth, followed by one stage for row and column, one for the first
// address multiply and one for the second address multiply.
// A stalled receiver holds the output stage; earlier stages keep filling
// bubbles, and req_tready falls only when all seven stages are full.
// Reset empties the pipeline and restores the registers to an identity map
// with one output batch, unit block and a one by one output.
module batch_to_space_address_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // in_batch_index, chan_block, in_row, in_col, lane0..lane3, zero pad
   input  logic [b2s_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_address, out_lane0..out_lane3, zero pad
   output logic [b2s_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // dropped
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [b2s_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [b2s_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NS = b2s_pkg::PIPE_STAGES;
   localparam int ND = b2s_pkg::DIV_STAGES;

   logic [8:0]  out_batch_ff;
   logic [4:0]  block_height_ff;
   logic [4:0]  block_width_ff;
   logic [11:0] crop_top_ff;
   logic [11:0] crop_left_ff;
   logic [12:0] out_height_ff;
   logic [12:0] out_width_ff;
   logic [10:0] channel_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_batch_ff      <= 9'd1;
         block_height_ff   <= 5'd1;
         block_width_ff    <= 5'd1;
         crop_top_ff       <= 12'd0;
         crop_left_ff      <= 12'd0;
         out_height_ff     <= 13'd1;
         out_width_ff      <= 13'd1;
         channel_blocks_ff <= 11'd1;
      end else if (csr_we) begin
         case (b2s_pkg::csr_index_type'(csr_index))
            b2s_pkg::REG_OUT_BATCH:      out_batch_ff      <= csr_wdata[8:0];
            b2s_pkg::REG_BLOCK_HEIGHT:   block_height_ff   <= csr_wdata[4:0];
            b2s_pkg::REG_BLOCK_WIDTH:    block_width_ff    <= csr_wdata[4:0];
            b2s_pkg::REG_CROP_TOP:       crop_top_ff       <= csr_wdata[11:0];
            b2s_pkg::REG_CROP_LEFT:      crop_left_ff      <= csr_wdata[11:0];
            b2s_pkg::REG_OUT_HEIGHT:     out_height_ff     <= csr_wdata[12:0];
            b2s_pkg::REG_OUT_WIDTH:      out_width_ff      <= csr_wdata[12:0];
            b2s_pkg::REG_CHANNEL_BLOCKS: channel_blocks_ff <= csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   // A zero batch count or block width behaves as one.
   logic [8:0] nb;
   logic [4:0] bw;
   assign nb = (out_batch_ff == 9'd0) ? 9'd1 : out_batch_ff;
   assign bw = (block_width_ff == 5'd0) ? 5'd1 : block_width_ff;

   // Stage k loads whenever it is empty or its contents move on.
   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;
   logic [NS-1:0] hold;

   always_comb begin
      en[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign hold       = vld_ff & ~en[NS:1];
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   b2s_pkg::div_type div_ff [ND];
   b2s_pkg::div_type div_in [ND];
   b2s_pkg::div_type req_word;

   always_comb begin
      req_word.ib       = req_tdata[15:0];
      req_word.rem_b    = '0;
      req_word.rem_w    = '0;
      req_word.quo_w    = '0;
      req_word.cb       = req_tdata[25:16];
      req_word.row_prod = req_tdata[37:26] * block_height_ff;
      req_word.col_prod = req_tdata[49:38] * bw;
      req_word.lanes    = req_tdata[177:50];
      div_in[0] = b2s_pkg::div_slice(req_word, nb, bw);
      for (int k = 1; k < ND; k++) begin
         div_in[k] = b2s_pkg::div_slice(div_ff[k-1], nb, bw);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ND; k++) begin
         if (en[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   b2s_pkg::pos_type pos_ff;
   b2s_pkg::pos_type pos_in;

   always_comb begin
      pos_in.base  = div_ff[ND-1].rem_b * channel_blocks_ff;
      pos_in.base  = pos_in.base + {11'd0, div_ff[ND-1].cb};
      pos_in.row   = {2'd0, div_ff[ND-1].row_prod} + {3'd0, div_ff[ND-1].quo_w}
                     - {7'd0, crop_top_ff};
      pos_in.col   = {2'd0, div_ff[ND-1].col_prod} + {14'd0, div_ff[ND-1].rem_w}
                     - {7'd0, crop_left_ff};
      pos_in.lanes = div_ff[ND-1].lanes;
   end

   always_ff @(posedge clock) begin
      if (en[ND]) begin
         pos_ff <= pos_in;
      end
   end

   b2s_pkg::mac_type mac_ff;
   b2s_pkg::mac_type mac_in;
   logic [33:0]      prod_h;

   always_comb begin
      prod_h       = pos_ff.base * out_height_ff;
      mac_in.drop  = pos_ff.row[18] || pos_ff.col[18]
                     || (pos_ff.row[17:0] >= {5'd0, out_height_ff})
                     || (pos_ff.col[17:0] >= {5'd0, out_width_ff});
      mac_in.part  = prod_h + {21'd0, pos_ff.row[12:0]};
      mac_in.col   = pos_ff.col[12:0];
      mac_in.lanes = pos_ff.lanes;
   end

   always_ff @(posedge clock) begin
      if (en[ND+1]) begin
         mac_ff <= mac_in;
      end
   end

   b2s_pkg::out_type out_ff;
   b2s_pkg::out_type out_in;
   logic [46:0]      prod_w;

   always_comb begin
      prod_w      = mac_ff.part * out_width_ff;
      out_in.drop = mac_ff.drop;
      if (mac_ff.drop) begin
         out_in.addr  = '0;
         out_in.lanes = '0;
      end else begin
         out_in.addr  = prod_w[41:0] + {29'd0, mac_ff.col};
         out_in.lanes = mac_ff.lanes;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ND+2]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tuser  = out_ff.drop;
   assign rsp_tdata  = {6'd0, out_ff.lanes, out_ff.addr};

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("dropped word carries nonzero data");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (hold != '0) |=> ((vld_ff & $past(hold)) == $past(hold)))
      else $error("stalled pipeline stage lost its word");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output stage is empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
